// File: hdl/rfbr_pkg.sv
// ----------------------------------------------------------------------------
// rfbr_pkg
// Shared constants, codes and types of the record-framed byte ring FIFO.
// ----------------------------------------------------------------------------
package rfbr_pkg;

  // Byte store geometry; pointers are one bit wider than the store index
  localparam int unsigned DEPTH_LOG2  = 12;
  localparam int unsigned STORE_DEPTH = 1 << DEPTH_LOG2;
  localparam int unsigned PTR_W       = DEPTH_LOG2 + 1;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned BYTE_W      = 8;
  // Width that holds a pointer, a length plus a header, and their sums
  localparam int unsigned CMP_W       = (PTR_W + 1 > LEN_W + 2) ? PTR_W + 1 : LEN_W + 2;

  typedef enum logic [2:0] {
    ACT_WRITE_BEGIN = 3'd0,
    ACT_WRITE_BYTE  = 3'd1,
    ACT_READ_BEGIN  = 3'd2,
    ACT_READ_BYTE   = 3'd3,
    ACT_SKIP        = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_SEQ    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_HDR_WR,
    S_HDR_LO,
    S_HDR_HI,
    S_RBYTE,
    S_RESULT
  } state_e;

  // One result item
  typedef struct packed {
    status_e             status;
    logic [BYTE_W-1:0]   out_byte;
    logic [LEN_W-1:0]    record_length;
    logic [LEN_W-1:0]    granted_length;
    logic                last;
  } result_t;

  // Byte store access request: one write and one read port
  typedef struct packed {
    logic                  we;
    logic [DEPTH_LOG2-1:0] waddr;
    logic [BYTE_W-1:0]     wdata;
    logic                  re;
    logic [DEPTH_LOG2-1:0] raddr;
  } mem_req_t;

endpackage

// File: hdl/rfbr_ram.sv
// ----------------------------------------------------------------------------
// rfbr_ram
// Byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rfbr_ram
  import rfbr_pkg::*;
(
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [STORE_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // Write the addressed byte
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rfbr_ctrl.sv
// ----------------------------------------------------------------------------
// rfbr_ctrl
// Command sequencer: pointers, pending write/read state, header fetch and
// result assembly around the byte store.
// ----------------------------------------------------------------------------
module rfbr_ctrl
  import rfbr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  // input items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        action_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic              consume_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  // result toward the output register
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o,
  // byte store
  output mem_req_t          mem_req_o,
  input  logic [BYTE_W-1:0] mem_rdata_i
);

  state_e state_q, state_d;

  logic [1:0]        hdr_cfg_q;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d, wc_q, wc_d, rc_q, rc_d;
  logic [LEN_W-1:0]  wrem_q, wrem_d, rrem_q, rrem_d, rsize_q, rsize_d;
  logic [1:0]        rhdr_q, rhdr_d;
  logic              rcons_q, rcons_d;

  // latched item and scratch
  action_e           act_q;
  logic [LEN_W-1:0]  len_q;
  logic              cons_q;
  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] hlo_q, hlo_d;
  result_t           res_q, res_d;

  // decode
  logic [1:0]        h;
  logic [PTR_W-1:0]  diff, used, free, body;
  logic              wr_pend, rd_pend, empty, reject, short_hdr;
  logic [LEN_W-1:0]  hv, rec_n, grant_s, sat_used;
  logic [1:0]        rec_hdr;
  logic [1:0]        fin_hdr;
  logic [LEN_W-1:0]  fin_n, fin_grant, fin_rlen;
  logic [CMP_W-1:0]  fin_adv, skip_adv;
  logic              fin_rd;

  // Derive occupancy, checks and head record figures
  always_comb begin
    h         = (hdr_cfg_q == 2'd3) ? 2'd2 : hdr_cfg_q;
    diff      = wp_q - rp_q;
    used      = (CMP_W'(diff) > CMP_W'(STORE_DEPTH)) ? PTR_W'(STORE_DEPTH) : diff;
    free      = PTR_W'(STORE_DEPTH) - used;
    wr_pend   = (wrem_q != '0);
    rd_pend   = (rrem_q != '0);
    empty     = (used == '0);
    reject    = ((h == 2'd1) && (len_q > LEN_W'(255))) ||
                ((CMP_W'(len_q) + CMP_W'(h)) > CMP_W'(free));
    short_hdr = (CMP_W'(used) < CMP_W'(h));
    hv        = (state_q == S_HDR_HI) ? {mem_rdata_i, hlo_q} : LEN_W'(mem_rdata_i);
    body      = used - PTR_W'(h);
    rec_n     = short_hdr ? '0 :
                ((CMP_W'(hv) > CMP_W'(body)) ? LEN_W'(body) : hv);
    rec_hdr   = short_hdr ? used[1:0] : h;
    grant_s   = (CMP_W'(len_q) < CMP_W'(used)) ? len_q : LEN_W'(used);
    sat_used  = (CMP_W'(used) > CMP_W'(16'hFFFF)) ? 16'hFFFF : LEN_W'(used);
    // Head record as a read or skip sees it
    if (h == 2'd0) begin
      fin_hdr   = 2'd0;
      fin_n     = grant_s;
      fin_grant = grant_s;
      fin_rlen  = sat_used;
      skip_adv  = CMP_W'(used);
    end else begin
      fin_hdr   = rec_hdr;
      fin_n     = rec_n;
      fin_grant = (len_q < rec_n) ? len_q : rec_n;
      fin_rlen  = rec_n;
      skip_adv  = CMP_W'(rec_hdr) + CMP_W'(rec_n);
    end
    fin_adv = CMP_W'(rp_q) + CMP_W'(fin_hdr) + CMP_W'(fin_n);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (act_q)
          ACT_WRITE_BEGIN: begin
            if (!wr_pend && !reject && (h == 2'd2)) state_d = S_HDR_WR;
            else state_d = S_RESULT;
          end
          ACT_READ_BEGIN, ACT_SKIP: begin
            if (!rd_pend && !empty && (h != 2'd0) && !short_hdr) state_d = S_HDR_LO;
            else state_d = S_RESULT;
          end
          ACT_READ_BYTE: begin
            if (rd_pend) state_d = S_RBYTE;
            else state_d = S_RESULT;
          end
          default: state_d = S_RESULT;
        endcase
      end
      S_HDR_WR: state_d = S_RESULT;
      S_HDR_LO: begin
        if (h == 2'd2) state_d = S_HDR_HI;
        else state_d = S_RESULT;
      end
      S_HDR_HI: state_d = S_RESULT;
      S_RBYTE:  state_d = S_RESULT;
      S_RESULT: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and store accesses
  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    wc_d      = wc_q;
    rc_d      = rc_q;
    wrem_d    = wrem_q;
    rrem_d    = rrem_q;
    rsize_d   = rsize_q;
    rhdr_d    = rhdr_q;
    rcons_d   = rcons_q;
    hlo_d     = hlo_q;
    res_d     = res_q;
    mem_req_o = '0;
    fin_rd    = 1'b0;

    unique case (state_q)
      S_EXEC: begin
        res_d = '0;
        case (act_q)
          ACT_WRITE_BEGIN: begin
            if (wr_pend) begin
              res_d.status = STAT_SEQ;
            end else if (reject) begin
              res_d.status = STAT_REJECT;
            end else begin
              // Reserve the record and drop in the low header byte, if headers are on
              mem_req_o.we    = (h != 2'd0);
              mem_req_o.waddr = wp_q[DEPTH_LOG2-1:0];
              mem_req_o.wdata = len_q[7:0];
              wc_d            = wp_q + PTR_W'(h);
              wrem_d          = len_q;
              if (len_q == '0) begin
                wp_d       = wp_q + PTR_W'(h);
                res_d.last = 1'b1;
              end
            end
          end
          ACT_WRITE_BYTE: begin
            if (!wr_pend) begin
              res_d.status = STAT_SEQ;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = wc_q[DEPTH_LOG2-1:0];
              mem_req_o.wdata = byte_q;
              wc_d            = wc_q + PTR_W'(1);
              wrem_d          = wrem_q - LEN_W'(1);
              // Commit on the last byte
              if (wrem_q == LEN_W'(1)) begin
                wp_d       = wc_q + PTR_W'(1);
                res_d.last = 1'b1;
              end
            end
          end
          ACT_READ_BEGIN, ACT_SKIP: begin
            if (rd_pend) begin
              res_d.status = STAT_SEQ;
            end else if (empty) begin
              res_d.status = STAT_REJECT;
            end else if ((h != 2'd0) && !short_hdr) begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = rp_q[DEPTH_LOG2-1:0];
            end else begin
              fin_rd = 1'b1;
            end
          end
          ACT_READ_BYTE: begin
            if (!rd_pend) begin
              res_d.status = STAT_SEQ;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = rc_q[DEPTH_LOG2-1:0];
            end
          end
          default: res_d.status = STAT_SEQ;
        endcase
      end
      S_HDR_WR: begin
        // High header byte sits just below the write cursor
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = DEPTH_LOG2'(wc_q - PTR_W'(1));
        mem_req_o.wdata = len_q[15:8];
      end
      S_HDR_LO: begin
        hlo_d = mem_rdata_i;
        if (h == 2'd2) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = DEPTH_LOG2'(rp_q + PTR_W'(1));
        end else begin
          fin_rd = 1'b1;
        end
      end
      S_HDR_HI: fin_rd = 1'b1;
      S_RBYTE: begin
        res_d.out_byte = mem_rdata_i;
        rc_d           = rc_q + PTR_W'(1);
        rrem_d         = rrem_q - LEN_W'(1);
        if (rrem_q == LEN_W'(1)) begin
          res_d.last = 1'b1;
          if (rcons_q) begin
            rp_d = PTR_W'(CMP_W'(rp_q) + CMP_W'(rhdr_q) + CMP_W'(rsize_q));
          end
        end
      end
      default: ;
    endcase

    // Finish a read_begin or skip once the head record is known
    if (fin_rd) begin
      res_d.record_length = fin_rlen;
      if (act_q == ACT_SKIP) begin
        rp_d = PTR_W'(CMP_W'(rp_q) + skip_adv);
      end else begin
        res_d.granted_length = fin_grant;
        rhdr_d  = fin_hdr;
        rsize_d = fin_n;
        rc_d    = rp_q + PTR_W'(fin_hdr);
        rrem_d  = fin_grant;
        rcons_d = cons_q;
        if (fin_grant == '0) begin
          res_d.last = 1'b1;
          if (cons_q) rp_d = PTR_W'(fin_adv);
        end
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      hdr_cfg_q <= 2'd1;
      wp_q      <= '0;
      rp_q      <= '0;
      wc_q      <= '0;
      rc_q      <= '0;
      wrem_q    <= '0;
      rrem_q    <= '0;
      rsize_q   <= '0;
      rhdr_q    <= '0;
      rcons_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) hdr_cfg_q <= cfg_wdata_i;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      wc_q    <= wc_d;
      rc_q    <= rc_d;
      wrem_q  <= wrem_d;
      rrem_q  <= rrem_d;
      rsize_q <= rsize_d;
      rhdr_q  <= rhdr_d;
      rcons_q <= rcons_d;
    end
  end

  // Hold the accepted item and scratch values
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= action_e'(action_i);
      len_q  <= length_i;
      cons_q <= consume_i;
      byte_q <= data_byte_i;
    end
    hlo_q <= hlo_d;
    res_q <= res_d;
  end

endmodule

// File: hdl/record_framed_byte_ring_fifo.sv
// ----------------------------------------------------------------------------
// record_framed_byte_ring_fifo
// Byte ring buffer with optional per-record length headers.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (action, length, consume, data_byte) enter on in_valid_i /
//   in_ready_o; each gives exactly one result item (status, out_byte,
//   record_length, granted_length, last) on out_valid_o / out_ready_i.
//   cfg_we_i writes header_bytes from cfg_wdata_i; write it only while idle.
//   One item is in work at a time. The sequencer takes it in S_IDLE, runs
//   the command on the byte store in S_EXEC, passes through a further state
//   for every store read or second header write (S_RBYTE for read_byte,
//   S_HDR_LO and, with two-byte headers, S_HDR_HI for a read_begin/skip that
//   fetches a header, S_HDR_WR for a two-byte-header write_begin), and hands
//   the result to the output register from S_RESULT.
//   A result waiting in the output register does not block the next item;
//   when the receiver stalls, the following result is held inside until the
//   output register frees up, and no further item is taken meanwhile.
//   Reset empties the ring, clears pending writes and reads and sets
//   header_bytes to 1. Store contents are not cleared; only written bytes
//   are ever read.
// ----------------------------------------------------------------------------
module record_framed_byte_ring_fifo
  import rfbr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        action_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic              consume_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic [LEN_W-1:0]  record_length_o,
  output logic [LEN_W-1:0]  granted_length_o,
  output logic              last_o
);

  mem_req_t          mem_req;
  logic [BYTE_W-1:0] mem_rdata;
  logic              res_valid, res_ready;
  result_t           res;
  logic              out_valid_q;
  result_t           out_q;

  rfbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .length_i    (length_i),
    .consume_i   (consume_i),
    .data_byte_i (data_byte_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  rfbr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign out_byte_o       = out_q.out_byte;
  assign record_length_o  = out_q.record_length;
  assign granted_length_o = out_q.granted_length;
  assign last_o           = out_q.last;

endmodule

// File: dv/record_framed_byte_ring_fifo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_framed_byte_ring_fifo_checker
// Watches the command and reply channels of the record ring FIFO, keeps its
// own copy of the ring, the pointers and the header setting, predicts one
// reply per accepted command and compares each accepted reply field by field.
// ----------------------------------------------------------------------------
module record_framed_byte_ring_fifo_checker
  import rfbr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [2:0]        action_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic              consume_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [1:0]        status_i,
  input  logic [BYTE_W-1:0] out_byte_i,
  input  logic [LEN_W-1:0]  record_length_i,
  input  logic [LEN_W-1:0]  granted_length_i,
  input  logic              last_i,
  output int                fail_count_o,
  output int                pending_o,
  output logic [LEN_W-1:0]  write_left_o,
  output logic [LEN_W-1:0]  read_left_o,
  output logic [PTR_W-1:0]  ring_fill_o
);

  localparam int unsigned HDR1_MAX    = 255;
  localparam logic [1:0]  HDR_RESET   = 2'd1;
  localparam int unsigned MAX_REPORTS = 40;

  // Shadow ring and its bookkeeping
  logic [BYTE_W-1:0] ring_mem [STORE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr, wr_cur, rd_cur;
  logic [LEN_W-1:0]  wr_left, rd_left, rd_size;
  logic              rd_consume;
  logic [1:0]        rd_span;
  logic [1:0]        hdr_cfg;
  result_t           reply_q [$];
  int                fail_cnt = 0;
  int                pend_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pend_cnt;
  assign write_left_o = wr_left;
  assign read_left_o  = rd_left;
  assign ring_fill_o  = wr_ptr - rd_ptr;

  function automatic logic [DEPTH_LOG2-1:0] slot(input logic [PTR_W-1:0] p);
    return p[DEPTH_LOG2-1:0];
  endfunction

  function automatic int unsigned fill_level();
    logic [PTR_W-1:0] diff;
    diff = wr_ptr - rd_ptr;
    return (diff > STORE_DEPTH) ? STORE_DEPTH : int'(diff);
  endfunction

  function automatic logic [LEN_W-1:0] sat_len(input int unsigned v);
    return (v > 32'hFFFF) ? 16'hFFFF : LEN_W'(v);
  endfunction

  // Length of the head record; span gets the header bytes it occupies
  function automatic int unsigned head_len(input int unsigned h, input int unsigned used,
                                           output int unsigned span);
    int unsigned      hv;
    int unsigned      body;
    logic [PTR_W-1:0] p;
    if (used < h) begin
      // fewer bytes than a header: zero-length record spanning them
      span = used;
      return 0;
    end
    span = h;
    hv   = int'(ring_mem[slot(rd_ptr)]);
    if (h == 2) begin
      p  = rd_ptr + 1'b1;
      hv = hv | (int'(ring_mem[slot(p)]) << BYTE_W);
    end
    body = used - h;
    // cut a damaged header to the bytes actually stored
    return (hv > body) ? body : hv;
  endfunction

  // Apply one command to the shadow ring and queue the reply it gives
  task automatic apply_ring_command(input logic [2:0] act, input logic [LEN_W-1:0] len,
                                    input logic cons, input logic [BYTE_W-1:0] db);
    result_t          r;
    int unsigned      h, used, span, n, grant;
    logic [PTR_W-1:0] p;
    r.status         = STAT_OK;
    r.out_byte       = '0;
    r.record_length  = '0;
    r.granted_length = '0;
    r.last           = 1'b0;
    h    = (hdr_cfg > 2'd2) ? 2 : int'(hdr_cfg);
    used = fill_level();
    span = 0;
    case (act)
      ACT_WRITE_BEGIN: begin
        if (wr_left != 0) begin
          r.status = STAT_SEQ;
        end else if ((h == 1 && len > HDR1_MAX) || (len + h > STORE_DEPTH - used)) begin
          r.status = STAT_REJECT;
        end else begin
          if (h >= 1) ring_mem[slot(wr_ptr)] = len[7:0];
          if (h == 2) begin
            p = wr_ptr + 1'b1;
            ring_mem[slot(p)] = len[15:8];
          end
          wr_cur   = PTR_W'(wr_ptr + h);
          wr_left  = len;
          // zero-length record commits at once
          if (len == 0) begin
            wr_ptr = wr_cur;
            r.last = 1'b1;
          end
        end
      end
      ACT_WRITE_BYTE: begin
        if (wr_left == 0) begin
          r.status = STAT_SEQ;
        end else begin
          ring_mem[slot(wr_cur)] = db;
          wr_cur  = wr_cur + 1'b1;
          wr_left = wr_left - 1'b1;
          if (wr_left == 0) begin
            wr_ptr = wr_cur;
            r.last = 1'b1;
          end
        end
      end
      ACT_READ_BEGIN: begin
        if (rd_left != 0) begin
          r.status = STAT_SEQ;
        end else if (used == 0) begin
          r.status = STAT_REJECT;
        end else begin
          if (h == 0) begin
            // stream mode: the whole stored count is one record
            grant           = (len < used) ? len : used;
            r.record_length = sat_len(used);
            n               = grant;
          end else begin
            n               = head_len(h, used, span);
            grant           = (len < n) ? len : n;
            r.record_length = LEN_W'(n);
          end
          r.granted_length = LEN_W'(grant);
          rd_span    = 2'(span);
          rd_size    = LEN_W'(n);
          rd_cur     = PTR_W'(rd_ptr + span);
          rd_left    = LEN_W'(grant);
          rd_consume = cons;
          // nothing granted: done now, drop the record if consuming
          if (grant == 0) begin
            r.last = 1'b1;
            if (cons) rd_ptr = PTR_W'(rd_ptr + span + n);
          end
        end
      end
      ACT_READ_BYTE: begin
        if (rd_left == 0) begin
          r.status = STAT_SEQ;
        end else begin
          r.out_byte = ring_mem[slot(rd_cur)];
          rd_cur  = rd_cur + 1'b1;
          rd_left = rd_left - 1'b1;
          if (rd_left == 0) begin
            r.last = 1'b1;
            if (rd_consume) rd_ptr = PTR_W'(rd_ptr + rd_span + rd_size);
          end
        end
      end
      ACT_SKIP: begin
        if (rd_left != 0) begin
          r.status = STAT_SEQ;
        end else if (used == 0) begin
          r.status = STAT_REJECT;
        end else if (h == 0) begin
          // stream mode: drop everything stored
          r.record_length = sat_len(used);
          rd_ptr = PTR_W'(rd_ptr + used);
        end else begin
          n = head_len(h, used, span);
          r.record_length = LEN_W'(n);
          rd_ptr = PTR_W'(rd_ptr + span + n);
        end
      end
      default: r.status = STAT_SEQ;
    endcase
    reply_q.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare an accepted reply against the oldest prediction
  task automatic check_reply();
    result_t want;
    if (reply_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: reply item with none expected, expected none, actual status %0d",
                 $time, status_i);
    end else begin
      want = reply_q.pop_front();
      compare_field("status", LEN_W'(want.status), LEN_W'(status_i));
      compare_field("out_byte", LEN_W'(want.out_byte), LEN_W'(out_byte_i));
      compare_field("record_length", want.record_length, record_length_i);
      compare_field("granted_length", want.granted_length, granted_length_i);
      compare_field("last", LEN_W'(want.last), LEN_W'(last_i));
    end
  endtask

  // Track resets, header writes, commands and replies
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr     = '0;
      rd_ptr     = '0;
      wr_cur     = '0;
      rd_cur     = '0;
      wr_left    = '0;
      rd_left    = '0;
      rd_size    = '0;
      rd_consume = 1'b0;
      rd_span    = '0;
      hdr_cfg    = HDR_RESET;
      reply_q.delete();
      pend_cnt   = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_reply();
      if (cfg_we_i) hdr_cfg = cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        apply_ring_command(action_i, length_i, consume_i, data_byte_i);
      pend_cnt = reply_q.size();
    end
  end

endmodule

// File: dv/tb_record_framed_byte_ring_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_framed_byte_ring_fifo
// Drives the record ring FIFO with a short directed run of corner cases and
// then phases of random record traffic under each header setting, with
// random gaps and stalls on both channels; the checker predicts the replies.
// ----------------------------------------------------------------------------
module tb_record_framed_byte_ring_fifo;
  import rfbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 244;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam logic [2:0]  ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        action = ACT_SKIP;
  logic [LEN_W-1:0]  length = '0;
  logic              consume = 1'b0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  record_length;
  logic [LEN_W-1:0]  granted_length;
  logic              last;

  int                fail_count;
  int                pending;
  logic [LEN_W-1:0]  write_left;
  logic [LEN_W-1:0]  read_left;
  logic [PTR_W-1:0]  ring_fill;

  int unsigned       cycle_count = 0;
  int unsigned       sent_count = 0;
  int unsigned       rx_count = 0;
  logic [1:0]        cur_hdr = 2'd1;

  record_framed_byte_ring_fifo u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .length_i         (length),
    .consume_i        (consume),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .out_byte_o       (out_byte),
    .record_length_o  (record_length),
    .granted_length_o (granted_length),
    .last_o           (last)
  );

  record_framed_byte_ring_fifo_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .length_i         (length),
    .consume_i        (consume),
    .data_byte_i      (data_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .status_i         (status),
    .out_byte_i       (out_byte),
    .record_length_i  (record_length),
    .granted_length_i (granted_length),
    .last_i           (last),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .write_left_o     (write_left),
    .read_left_o      (read_left),
    .ring_fill_o      (ring_fill)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[record_framed_byte_ring_fifo] ERROR");
      $finish;
    end
  end

  // Idle for a drawn number of cycles, then settle before choosing the item
  task automatic idle_then_sample();
    int unsigned gap;
    gap = ((sent_count / 128) % 5 == 2) ? 0 : $urandom_range(0, 8);
    repeat (gap) @(posedge clk);
    @(negedge clk);
  endtask

  // Offer one item and hold it until accepted
  task automatic drive_item(input logic [2:0] act, input logic [LEN_W-1:0] len,
                            input logic cons, input logic [BYTE_W-1:0] db);
    @(posedge clk);
    in_valid  <= 1'b1;
    action    <= act;
    length    <= len;
    consume   <= cons;
    data_byte <= db;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    sent_count++;
  endtask

  task automatic send_fixed(input logic [2:0] act, input logic [LEN_W-1:0] len,
                            input logic cons, input logic [BYTE_W-1:0] db);
    idle_then_sample();
    drive_item(act, len, cons, db);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Choose the next command from where the ring stands: mostly complete
  // record writes and reads, some rejections, some noise
  task automatic pick_command(output logic [2:0] act, output logic [LEN_W-1:0] len,
                              output logic cons, output logic [BYTE_W-1:0] db);
    int unsigned roll, h, room, write_share;
    h    = (cur_hdr > 2'd2) ? 2 : int'(cur_hdr);
    room = STORE_DEPTH - int'(ring_fill);
    len  = LEN_W'($urandom);
    cons = 1'($urandom_range(0, 1));
    db   = BYTE_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      act = 3'($urandom_range(0, 7));
    end else if (write_left != 0 && (read_left == 0 || $urandom_range(0, 1) == 1)) begin
      act = ACT_WRITE_BYTE;
    end else if (read_left != 0) begin
      act = ACT_READ_BYTE;
    end else begin
      write_share = (ring_fill > 3000) ? 20 : 45;
      roll = $urandom_range(0, 99);
      if (roll < write_share) begin
        act = ACT_WRITE_BEGIN;
        case ($urandom_range(0, 19))
          0: len = '0;
          1: len = 16'd255;
          2: len = 16'd256;
          3: len = LEN_W'(room - h + 1);
          4: len = 16'hFFFF;
          5: ;
          default: len = LEN_W'($urandom_range(1, 24));
        endcase
      end else if (roll < 85) begin
        act = ACT_READ_BEGIN;
        case ($urandom_range(0, 9))
          0: len = '0;
          1: len = 16'hFFFF;
          2: ;
          default: len = LEN_W'($urandom_range(1, 30));
        endcase
        cons = ($urandom_range(0, 3) != 0);
      end else begin
        act = ACT_SKIP;
      end
    end
  endtask

  // Reply side: random stalls, quiet stretches and two long hold-offs
  initial begin : reply_sink
    int unsigned gap;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_count == 250 || rx_count == 1100) gap = LONG_HOLD;
      else if ((rx_count / 160) % 5 == 3) gap = 0;
      else gap = $urandom_range(0, 8);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_count++;
    end
  end

  // Command side and verdict
  initial begin : command_source
    logic [2:0]        act;
    logic [LEN_W-1:0]  len;
    logic              cons;
    logic [BYTE_W-1:0] db;
    logic [1:0]        next_hdr;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Corner cases under the reset header size of one byte
    send_fixed(ACT_READ_BEGIN, 16'd5, 1'b1, 8'h00);     // empty ring
    send_fixed(ACT_SKIP, 16'd0, 1'b0, 8'h00);           // empty ring
    send_fixed(ACT_WRITE_BYTE, 16'd0, 1'b0, 8'hFF);     // no write pending
    send_fixed(ACT_READ_BYTE, 16'hFFFF, 1'b1, 8'h00);   // no read pending
    send_fixed(ACT_UNUSED_LO, 16'd0, 1'b0, 8'h00);
    send_fixed(ACT_UNUSED_HI, 16'hFFFF, 1'b1, 8'hFF);
    send_fixed(ACT_WRITE_BEGIN, 16'd256, 1'b0, 8'h00);  // too long for the header
    send_fixed(ACT_WRITE_BEGIN, 16'hFFFF, 1'b0, 8'h00); // no room
    send_fixed(ACT_WRITE_BEGIN, 16'd0, 1'b0, 8'h00);    // commits at once
    send_fixed(ACT_WRITE_BEGIN, 16'd3, 1'b0, 8'h00);
    send_fixed(ACT_WRITE_BEGIN, 16'd1, 1'b0, 8'h00);    // write already pending
    send_fixed(ACT_WRITE_BYTE, 16'd0, 1'b0, 8'h00);
    send_fixed(ACT_WRITE_BYTE, 16'd0, 1'b0, 8'hFF);
    send_fixed(ACT_WRITE_BYTE, 16'd0, 1'b0, 8'hA5);
    send_fixed(ACT_READ_BEGIN, 16'd0, 1'b0, 8'h00);     // nothing granted, peek
    send_fixed(ACT_SKIP, 16'd0, 1'b0, 8'h00);           // drop the empty record
    send_fixed(ACT_READ_BEGIN, 16'd2, 1'b1, 8'h00);     // partial grant, consume
    send_fixed(ACT_SKIP, 16'd0, 1'b0, 8'h00);           // read still pending
    send_fixed(ACT_READ_BYTE, 16'd0, 1'b0, 8'h00);
    send_fixed(ACT_READ_BYTE, 16'd0, 1'b0, 8'h00);
    send_fixed(ACT_READ_BEGIN, 16'hFFFF, 1'b1, 8'h00);  // whole record gone
    send_fixed(ACT_WRITE_BEGIN, 16'd255, 1'b0, 8'h00);  // longest one-byte record

    // Random traffic, one header setting per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: next_hdr = 2'd2;
        1: next_hdr = 2'd0;
        2: next_hdr = 2'd3;
        3: next_hdr = 2'd1;
        4: next_hdr = 2'd0;
        5: next_hdr = 2'd2;
        6: next_hdr = 2'd3;
        default: next_hdr = 2'd1;
      endcase
      wait_drained();
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= next_hdr;
      @(posedge clk);
      cfg_we  <= 1'b0;
      cur_hdr = next_hdr;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        idle_then_sample();
        pick_command(act, len, cons, db);
        drive_item(act, len, cons, db);
      end
    end

    // Let every reply arrive, then watch for strays
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("[record_framed_byte_ring_fifo] OK");
    end else begin
      $display("[record_framed_byte_ring_fifo] ERROR");
    end
    $finish;
  end

endmodule

// File: record_framed_byte_ring_fifo.f
hdl/rfbr_pkg.sv
hdl/rfbr_ram.sv
hdl/rfbr_ctrl.sv
hdl/record_framed_byte_ring_fifo.sv
dv/record_framed_byte_ring_fifo_checker.sv
dv/tb_record_framed_byte_ring_fifo.sv
